>>> rtl/symbol_and_pair_histogram_macros.svh
// Assertion macros for the histogram RTL.
`ifndef SYMBOL_AND_PAIR_HISTOGRAM_MACROS_SVH
`define SYMBOL_AND_PAIR_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS
`define SPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/sph_pkg.sv
package sph_pkg;

    localparam int SPH_MAX_LEN = 32;
    localparam int SPH_SYM_W   = 8;
    localparam int SPH_CNT_W   = 6;

    typedef struct packed {
        logic absorb;
        logic shift;
    } t_chain_ctrl;

    typedef struct packed {
        logic absorb;
        logic insert;
        logic occupied;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> rtl/sph_in_if.sv
interface sph_in_if import sph_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SPH_SYM_W-1:0] symbol;
    logic                 last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> rtl/sph_out_if.sv
interface sph_out_if import sph_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 is_pair;
    logic [SPH_SYM_W-1:0] first_symbol;
    logic [SPH_SYM_W-1:0] second_symbol;
    logic [SPH_CNT_W-1:0] occurrences;
    logic                 truncated;
    logic                 final_result;

    modport source (output valid, output is_pair, output first_symbol, output second_symbol,
                    output occurrences, output truncated, output final_result, input ready);
    modport sink   (input valid, input is_pair, input first_symbol, input second_symbol,
                    input occurrences, input truncated, input final_result, output ready);
endinterface

>>> rtl/sph_cell.sv
module sph_cell import sph_pkg::*; #(
    parameter int KEY_W = SPH_SYM_W
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [KEY_W-1:0]     i_next_key,
    input  logic [SPH_CNT_W-1:0] i_next_count,
    output logic [KEY_W-1:0]     o_key,
    output logic [SPH_CNT_W-1:0] o_count,
    output logic                 o_hit
);

    logic [KEY_W-1:0]     r_key;
    logic [SPH_CNT_W-1:0] r_count;

    assign o_hit   = i_ctrl.occupied && (r_key == i_key);
    assign o_key   = r_key;
    assign o_count = r_count;

    // During read-out every cell takes its neighbour's entry, so the head cell
    // always holds the oldest remaining key.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_next_key;
            r_count <= i_next_count;
        end else if (i_ctrl.insert) begin
            r_key   <= i_key;
            r_count <= SPH_CNT_W'(1);
        end else if (i_ctrl.absorb && o_hit) begin
            r_count <= r_count + SPH_CNT_W'(1);
        end
    end

endmodule

>>> rtl/sph_chain.sv
module sph_chain import sph_pkg::*; #(
    parameter int DEPTH = SPH_MAX_LEN,
    parameter int KEY_W = SPH_SYM_W,
    localparam int USED_W = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_chain_ctrl          i_ctrl,
    input  logic [KEY_W-1:0]     i_key,
    output logic [KEY_W-1:0]     o_key,
    output logic [SPH_CNT_W-1:0] o_count,
    output logic [USED_W-1:0]    o_used
);

    logic [DEPTH-1:0]     w_hit;
    logic [KEY_W-1:0]     w_key   [DEPTH];
    logic [SPH_CNT_W-1:0] w_count [DEPTH];
    logic                 w_any_hit;
    logic                 w_full;
    logic [USED_W-1:0]    r_used;

    assign w_any_hit = |w_hit;
    assign w_full    = (r_used == USED_W'(DEPTH));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NX = (g < DEPTH - 1) ? g + 1 : g;
        t_cell_ctrl w_ctrl;

        assign w_ctrl.absorb   = i_ctrl.absorb;
        assign w_ctrl.shift    = i_ctrl.shift;
        assign w_ctrl.occupied = (r_used > USED_W'(g));
        assign w_ctrl.insert   = i_ctrl.absorb && !w_any_hit && (r_used == USED_W'(g));

        sph_cell #(.KEY_W(KEY_W)) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_key        (i_key),
            .i_next_key   (w_key[NX]),
            .i_next_count (w_count[NX]),
            .o_key        (w_key[g]),
            .o_count      (w_count[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctrl.shift) begin
            r_used <= r_used - USED_W'(1);
        end else if (i_ctrl.absorb && !w_any_hit && !w_full) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    assign o_key   = w_key[0];
    assign o_count = w_count[0];
    assign o_used  = r_used;

endmodule

>>> rtl/symbol_and_pair_histogram.sv
// Byte and byte-pair histogram of one string.
// Input channel i_in carries one byte (symbol) per request, with last set on
// the final byte of the string. Output channel o_out carries one count per
// request: first every distinct adjacent pair, then every distinct byte, each
// group in order of first appearance, with final_result set on the last one.
// Up to MAX_LEN bytes are kept; later bytes are dropped and every result of
// that string carries truncated.
// Each stored byte is absorbed with every cell of the pair and byte rows
// comparing its key at once. Accepting the last byte sets the emit state; the
// output register takes the first result, and further results follow one per
// cycle while the receiver is ready; read-out shifts the cell rows towards the
// head cell once per result. No new byte is taken during read-out.
// A stalled receiver holds the output register and the read-out waits with it.
// Reset empties both rows and clears the length and the truncation flag; the
// block is then ready for a byte.
`include "symbol_and_pair_histogram_macros.svh"

module symbol_and_pair_histogram import sph_pkg::*; #(
    parameter int MAX_LEN = SPH_MAX_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sph_in_if.sink    i_in,
    sph_out_if.source o_out
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int PAIR_W = $clog2(MAX_LEN);
    localparam int SGL_W  = $clog2(MAX_LEN + 1);

    logic [LEN_W-1:0]       r_len;
    logic [SPH_SYM_W-1:0]   r_prev;
    logic                   r_ovf;
    logic                   r_emit;
    logic                   r_out_valid;
    logic                   r_is_pair;
    logic [SPH_SYM_W-1:0]   r_first;
    logic [SPH_SYM_W-1:0]   r_second;
    logic [SPH_CNT_W-1:0]   r_occ;
    logic                   r_trunc;
    logic                   r_final;

    logic                   w_take;
    logic                   w_store;
    logic                   w_slot;
    logic                   w_step;
    logic                   w_pair_sel;
    logic                   w_final;
    t_chain_ctrl            w_pair_ctrl;
    t_chain_ctrl            w_sgl_ctrl;
    logic [2*SPH_SYM_W-1:0] w_pair_key;
    logic [SPH_CNT_W-1:0]   w_pair_cnt;
    logic [PAIR_W-1:0]      w_pair_used;
    logic [SPH_SYM_W-1:0]   w_sgl_key;
    logic [SPH_CNT_W-1:0]   w_sgl_cnt;
    logic [SGL_W-1:0]       w_sgl_used;

    assign i_in.ready = !r_emit;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_store    = w_take && (r_len < LEN_W'(MAX_LEN));

    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_step     = r_emit && w_slot;
    assign w_pair_sel = (w_pair_used != '0);
    assign w_final    = w_pair_sel ? ((w_pair_used == PAIR_W'(1)) && (w_sgl_used == '0))
                                   : (w_sgl_used == SGL_W'(1));

    // A pair is only formed once a previous byte of this string exists.
    assign w_pair_ctrl.absorb = w_store && (r_len != '0);
    assign w_pair_ctrl.shift  = w_step && w_pair_sel;
    assign w_sgl_ctrl.absorb  = w_store;
    assign w_sgl_ctrl.shift   = w_step && !w_pair_sel;

    sph_chain #(.DEPTH(MAX_LEN - 1), .KEY_W(2 * SPH_SYM_W)) u_pairs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pair_ctrl),
        .i_key   ({r_prev, i_in.symbol}),
        .o_key   (w_pair_key),
        .o_count (w_pair_cnt),
        .o_used  (w_pair_used)
    );

    sph_chain #(.DEPTH(MAX_LEN), .KEY_W(SPH_SYM_W)) u_singles (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_sgl_ctrl),
        .i_key   (i_in.symbol),
        .o_key   (w_sgl_key),
        .o_count (w_sgl_cnt),
        .o_used  (w_sgl_used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_prev      <= '0;
            r_ovf       <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_store) begin
                r_len  <= r_len + LEN_W'(1);
                r_prev <= i_in.symbol;
            end
            if (w_take && !w_store) begin
                r_ovf <= 1'b1;
            end
            if (w_take && i_in.last) begin
                r_emit <= 1'b1;
            end
            if (w_step && w_final) begin
                r_len  <= '0;
                r_prev <= '0;
                r_ovf  <= 1'b0;
                r_emit <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_is_pair <= w_pair_sel;
            r_first   <= w_pair_sel ? w_pair_key[2*SPH_SYM_W-1:SPH_SYM_W] : w_sgl_key;
            r_second  <= w_pair_sel ? w_pair_key[SPH_SYM_W-1:0] : '0;
            r_occ     <= w_pair_sel ? w_pair_cnt : w_sgl_cnt;
            r_trunc   <= r_ovf;
            r_final   <= w_final;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.is_pair       = r_is_pair;
    assign o_out.first_symbol  = r_first;
    assign o_out.second_symbol = r_second;
    assign o_out.occurrences   = r_occ;
    assign o_out.truncated     = r_trunc;
    assign o_out.final_result  = r_final;

    `SPH_ASSERT_IMP(a_empty_when_idle, i_clk, i_rst_n,
                    (r_len == '0) && !r_emit, (w_pair_used == '0) && (w_sgl_used == '0))
    `SPH_ASSERT_IMP(a_singles_within_len, i_clk, i_rst_n,
                    1'b1, SGL_W'(w_sgl_used) <= SGL_W'(r_len))
    `SPH_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, w_step && w_final,
                     !r_emit && (r_len == '0) && (w_sgl_used == '0) && (w_pair_used == '0))

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import sph_pkg::*;

    localparam int MAX_LEN      = SPH_MAX_LEN;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic                 is_pair;
        logic [SPH_SYM_W-1:0] first_symbol;
        logic [SPH_SYM_W-1:0] second_symbol;
        logic [SPH_CNT_W-1:0] occurrences;
        logic                 truncated;
        logic                 final_result;
    } t_count_entry;

    logic i_clk;
    logic i_rst_n;

    sph_in_if  symbol_ch ();
    sph_out_if count_ch ();

    symbol_and_pair_histogram u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (symbol_ch),
        .o_out   (count_ch)
    );

    // Predicted histogram state for the string being received.
    logic [15:0]          pair_key  [MAX_LEN-1];
    logic [SPH_CNT_W-1:0] pair_cnt  [MAX_LEN-1];
    int                   pair_n;
    logic [7:0]           byte_key  [MAX_LEN];
    logic [SPH_CNT_W-1:0] byte_cnt  [MAX_LEN];
    int                   byte_n;
    logic [7:0]           prev_symbol;
    int                   string_len;
    logic                 bytes_lost;

    t_count_entry pending_counts [$];
    int           mismatches;
    int           symbols_sent;
    int           quiet_cycles;
    logic         full_rate;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Updates the predicted histogram with one accepted byte and, on the last
    // byte, queues every count the block owes for the string.
    task automatic absorb_symbol(input logic [7:0] sym, input logic last_flag);
        logic [15:0]  key;
        int           i;
        int           total;
        t_count_entry entry;
        if (string_len < MAX_LEN) begin
            if (string_len > 0) begin
                key = {prev_symbol, sym};
                i = 0;
                while (i < pair_n && pair_key[i] != key) i++;
                if (i < pair_n) begin
                    pair_cnt[i] = pair_cnt[i] + 1'b1;
                end else if (pair_n < MAX_LEN - 1) begin
                    pair_key[pair_n] = key;
                    pair_cnt[pair_n] = 1;
                    pair_n++;
                end
            end
            i = 0;
            while (i < byte_n && byte_key[i] != sym) i++;
            if (i < byte_n) begin
                byte_cnt[i] = byte_cnt[i] + 1'b1;
            end else if (byte_n < MAX_LEN) begin
                byte_key[byte_n] = sym;
                byte_cnt[byte_n] = 1;
                byte_n++;
            end
            prev_symbol = sym;
            string_len++;
        end else begin
            bytes_lost = 1'b1;
        end
        if (!last_flag)
            return;
        total = pair_n + byte_n;
        for (i = 0; i < total; i++) begin
            entry.is_pair       = (i < pair_n);
            entry.first_symbol  = (i < pair_n) ? pair_key[i][15:8] : byte_key[i - pair_n];
            entry.second_symbol = (i < pair_n) ? pair_key[i][7:0] : 8'h00;
            entry.occurrences   = (i < pair_n) ? pair_cnt[i] : byte_cnt[i - pair_n];
            entry.truncated     = bytes_lost;
            entry.final_result  = (i == total - 1);
            pending_counts.push_back(entry);
        end
        pair_n      = 0;
        byte_n      = 0;
        prev_symbol = 8'h00;
        string_len  = 0;
        bytes_lost  = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next request can follow without a gap.
    task automatic send_symbol(input logic [7:0] sym, input logic last_flag);
        while (!full_rate && $urandom_range(0, 99) < 36) begin
            symbol_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        symbol_ch.valid  <= 1'b1;
        symbol_ch.symbol <= sym;
        symbol_ch.last   <= last_flag;
        @(posedge i_clk);
        while (!symbol_ch.ready) @(posedge i_clk);
        absorb_symbol(sym, last_flag);
        symbols_sent++;
        @(negedge i_clk);
    endtask

    // A span of zero draws from all byte values; otherwise from a small run of
    // values so that pairs and bytes repeat.
    task automatic send_string(input int len, input int span);
        logic [7:0] base;
        logic [7:0] sym;
        int         k;
        base = $urandom_range(0, 255);
        for (k = 0; k < len; k++) begin
            sym = (span == 0) ? 8'($urandom_range(0, 255))
                              : 8'(base + $urandom_range(0, span - 1));
            send_symbol(sym, k == len - 1);
        end
    endtask

    task automatic wait_for_counts();
        symbol_ch.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        // One-byte strings: a zero byte and an all-ones byte.
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        // Zero bytes inside a string do not end it.
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hA5, 1'b0);
        send_symbol(8'h5A, 1'b0);
        send_symbol(8'hA5, 1'b0);
        send_symbol(8'hA5, 1'b1);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'hFE, 1'b1);
        wait_for_counts();
    endtask

    task automatic test_capacity();
        logic [7:0] base;
        int         k;
        // A full string of one byte gives the largest counts, with no loss.
        base = $urandom_range(0, 255);
        for (k = 0; k < MAX_LEN; k++)
            send_symbol(base, k == MAX_LEN - 1);
        wait_for_counts();
        // Distinct bytes fill both rows; the last byte arrives after capacity
        // and must still close the string.
        base = $urandom_range(0, 255);
        for (k = 0; k < MAX_LEN + 2; k++)
            send_symbol(8'(base + k * 37), k == MAX_LEN + 1);
        wait_for_counts();
        send_string(MAX_LEN + 5, 3);
        wait_for_counts();
    endtask

    task automatic test_random_strings(input int upto);
        int pick;
        int len;
        while (symbols_sent < upto) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(1, 10);
            else if (pick < 9)
                len = $urandom_range(11, MAX_LEN - 1);
            else
                len = $urandom_range(MAX_LEN, MAX_LEN + 8);
            send_string(len, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            if ($urandom_range(0, 9) == 0)
                wait_for_counts();
        end
        wait_for_counts();
    endtask

    task automatic test_full_rate(input int upto);
        full_rate = 1'b1;
        while (symbols_sent < upto)
            send_string($urandom_range(1, 12), $urandom_range(0, 4));
        wait_for_counts();
        full_rate = 1'b0;
    endtask

    always @(negedge i_clk)
        count_ch.ready <= full_rate || ($urandom_range(0, 99) >= 36);

    always @(posedge i_clk) begin : check_counts
        t_count_entry want;
        if (i_rst_n && count_ch.valid && count_ch.ready) begin
            if (pending_counts.size() == 0) begin
                report("count delivered with no count pending");
            end else begin
                want = pending_counts.pop_front();
                compare_field("is_pair", count_ch.is_pair, want.is_pair);
                compare_field("first_symbol", count_ch.first_symbol, want.first_symbol);
                compare_field("second_symbol", count_ch.second_symbol, want.second_symbol);
                compare_field("occurrences", count_ch.occurrences, want.occurrences);
                compare_field("truncated", count_ch.truncated, want.truncated);
                compare_field("final_result", count_ch.final_result, want.final_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (symbol_ch.valid && symbol_ch.ready)
                || (count_ch.valid && count_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        symbol_ch.valid  = 1'b0;
        symbol_ch.symbol = 8'h00;
        symbol_ch.last   = 1'b0;
        count_ch.ready   = 1'b0;
        full_rate        = 1'b0;
        mismatches       = 0;
        symbols_sent     = 0;
        quiet_cycles     = 0;
        pair_n           = 0;
        byte_n           = 0;
        prev_symbol      = 8'h00;
        string_len       = 0;
        bytes_lost       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_random_strings(360);
        test_full_rate(400);
        test_random_strings(430);

        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
